// ----- rtl/svcut_pkg.sv -----
// servo cut sequencer package: phase and opcode codes, register indexes, field widths
// no dependencies; used by servo_cut_sequencer
`timescale 1ns / 1ps

package svcut_pkg;

	localparam int ANGLE_W   = 8;
	localparam int COUNT_W   = 8;
	localparam int DELAY_W   = 16;
	localparam int PWM_W     = 15;
	localparam int OPCODE_W  = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;
	localparam int ANGLE_NUM = 1 << ANGLE_W;

	typedef enum logic [1:0] {
		PH_IDLE      = 2'd0,
		PH_START     = 2'd1,
		PH_CUTTING   = 2'd2,
		PH_RELEASING = 2'd3
	} phase_t;

	typedef enum logic [OPCODE_W-1:0] {
		OP_TICK      = 2'd0,
		OP_START     = 2'd1,
		OP_SET_ANGLE = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CUT_ANGLE     = 3'd0,
		REG_MID_REL_ANGLE = 3'd1,
		REG_OFF_ANGLE     = 3'd2,
		REG_CUT_DELAY     = 3'd3,
		REG_REL_DELAY     = 3'd4,
		REG_CUT_ENABLE    = 3'd5
	} reg_idx_t;

	localparam logic [ANGLE_W-1:0] CUT_ANGLE_RST     = 8'd180;
	localparam logic [ANGLE_W-1:0] MID_REL_ANGLE_RST = 8'd90;
	localparam logic [ANGLE_W-1:0] OFF_ANGLE_RST     = 8'd0;
	localparam logic [DELAY_W-1:0] CUT_DELAY_RST     = 16'd450;
	localparam logic [DELAY_W-1:0] REL_DELAY_RST     = 16'd450;

endpackage

// ----- rtl/servo_cut_sequencer.sv -----
// servo cut sequencer top level: phase machine, delay timer and angle to compare mapping
// depends on svcut_pkg
`timescale 1ns / 1ps

// Servo cutter sequencer. Each input beat is a tick (one millisecond), a start
// command or a direct set-angle command; each produces exactly one output beat
// carrying the compare value now driving the servo, a flag telling whether this
// beat rewrote it, and the phase after the step. A tick first counts the delay
// timer down (it stops at zero) and then steps the phase machine
// idle -> start -> cutting -> releasing -> start/idle; a start command loads the
// cut count (zero counts as one) and only launches a run from idle. Angles outside
// MIN_ANGLE..MAX_ANGLE are ignored. With cut_enable low the phases still run but
// the sequenced angles leave the compare value alone. Throughput is one beat per
// clock while the result stream is not stalled by m_tready; each beat passes the
// input register and then the result register, with the phase update and a
// single constant-table lookup for the angle mapping between them. Configuration
// writes are always accepted and should only be done while no beat is in flight.
module servo_cut_sequencer #(
	parameter int MIN_ANGLE = 0,
	parameter int MAX_ANGLE = 180,
	parameter int MIN_PULSE = 7373,
	parameter int MAX_PULSE = 17203
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] cut_count, [15:8] angle
	input  logic [1:0]  s_tuser,   // [1:0] opcode
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [14:0] pwm_compare, [15] zero
	output logic [2:0]  m_tuser,   // [0] pwm_updated, [2:1] status
	// register write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int ASPAN = MAX_ANGLE - MIN_ANGLE;
	localparam int PSPAN = MAX_PULSE - MIN_PULSE;
	localparam int ADIV  = (ASPAN > 0) ? ASPAN : 1;

	// configuration registers
	logic [svcut_pkg::ANGLE_W-1:0] cut_angle_q;
	logic [svcut_pkg::ANGLE_W-1:0] mid_rel_angle_q;
	logic [svcut_pkg::ANGLE_W-1:0] off_angle_q;
	logic [svcut_pkg::DELAY_W-1:0] cut_delay_q;
	logic [svcut_pkg::DELAY_W-1:0] rel_delay_q;
	logic                          cut_enable_q;

	// input stage
	logic                            valid_s1;
	logic [svcut_pkg::OPCODE_W-1:0]  opcode_s1;
	logic [svcut_pkg::COUNT_W-1:0]   cut_count_s1;
	logic [svcut_pkg::ANGLE_W-1:0]   angle_s1;

	// sequencer state
	svcut_pkg::phase_t             phase_q, phase_d;
	logic [svcut_pkg::COUNT_W-1:0] cuts_left_q, cuts_left_d;
	logic [svcut_pkg::DELAY_W-1:0] delay_left_q, delay_left_d;
	logic [svcut_pkg::PWM_W-1:0]   compare_q, compare_d;

	// result register
	logic                          m_tvalid_q;
	logic [svcut_pkg::PWM_W-1:0]   pwm_compare_s2;
	logic                          pwm_updated_s2;
	logic [1:0]                    status_s2;

	logic                          advance;
	logic                          step;
	logic                          upd;
	logic                          map_req;
	logic [svcut_pkg::ANGLE_W-1:0] map_angle;
	logic [svcut_pkg::DELAY_W-1:0] delay_dec;

	// angle to compare value table, worked out at elaboration
	logic [svcut_pkg::PWM_W-1:0] map_val [svcut_pkg::ANGLE_NUM];
	logic                        map_ok  [svcut_pkg::ANGLE_NUM];

	for (genvar g = 0; g < svcut_pkg::ANGLE_NUM; g++) begin : g_map
		localparam int MAPV = (ASPAN > 0) ?
			((g - MIN_ANGLE) * PSPAN / ADIV + MIN_PULSE) : MIN_PULSE;
		localparam bit OK = (g >= MIN_ANGLE) && (g <= MAX_ANGLE);
		assign map_val[g] = svcut_pkg::PWM_W'(MAPV);
		assign map_ok[g]  = OK;
	end

	// handshakes: the result register frees up when its beat is taken
	assign advance   = !m_tvalid_q || m_tready;
	assign s_tready  = !valid_s1 || advance;
	assign step      = valid_s1 && advance;
	assign cfg_ready = 1'b1;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, pwm_compare_s2};
	assign m_tuser  = {status_s2, pwm_updated_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cut_angle_q     <= svcut_pkg::CUT_ANGLE_RST;
			mid_rel_angle_q <= svcut_pkg::MID_REL_ANGLE_RST;
			off_angle_q     <= svcut_pkg::OFF_ANGLE_RST;
			cut_delay_q     <= svcut_pkg::CUT_DELAY_RST;
			rel_delay_q     <= svcut_pkg::REL_DELAY_RST;
			cut_enable_q    <= 1'b1;
		end else if (cfg_valid) begin
			case (svcut_pkg::reg_idx_t'(cfg_index))
				svcut_pkg::REG_CUT_ANGLE:     cut_angle_q     <= cfg_data[7:0];
				svcut_pkg::REG_MID_REL_ANGLE: mid_rel_angle_q <= cfg_data[7:0];
				svcut_pkg::REG_OFF_ANGLE:     off_angle_q     <= cfg_data[7:0];
				svcut_pkg::REG_CUT_DELAY:     cut_delay_q     <= cfg_data;
				svcut_pkg::REG_REL_DELAY:     rel_delay_q     <= cfg_data;
				svcut_pkg::REG_CUT_ENABLE:    cut_enable_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			opcode_s1    <= s_tuser;
			cut_count_s1 <= s_tdata[7:0];
			angle_s1     <= s_tdata[15:8];
		end
	end

	// sequencer state register, updated once per processed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= svcut_pkg::PH_IDLE;
			cuts_left_q  <= svcut_pkg::COUNT_W'(1);
			delay_left_q <= svcut_pkg::CUT_DELAY_RST;
			compare_q    <= svcut_pkg::PWM_W'(MIN_PULSE);
		end else if (step) begin
			phase_q      <= phase_d;
			cuts_left_q  <= cuts_left_d;
			delay_left_q <= delay_left_d;
			compare_q    <= compare_d;
		end
	end

	assign delay_dec = (delay_left_q != '0) ?
		delay_left_q - svcut_pkg::DELAY_W'(1) : '0;

	// next state; any angle command goes through the one table lookup
	always_comb begin
		phase_d      = phase_q;
		cuts_left_d  = cuts_left_q;
		delay_left_d = delay_left_q;
		map_req      = 1'b0;
		map_angle    = angle_s1;
		case (svcut_pkg::op_t'(opcode_s1))
			svcut_pkg::OP_TICK: begin
				delay_left_d = delay_dec;
				case (phase_q)
					svcut_pkg::PH_START: begin
						delay_left_d = cut_delay_q;
						map_req      = cut_enable_q;
						map_angle    = cut_angle_q;
						phase_d      = svcut_pkg::PH_CUTTING;
					end
					svcut_pkg::PH_CUTTING: begin
						if (delay_dec == '0) begin
							// between cuts park at mid release, after the last at rest
							map_req      = cut_enable_q;
							map_angle    = (cuts_left_q > svcut_pkg::COUNT_W'(1)) ?
								mid_rel_angle_q : off_angle_q;
							phase_d      = svcut_pkg::PH_RELEASING;
							delay_left_d = rel_delay_q;
						end
					end
					svcut_pkg::PH_RELEASING: begin
						if (delay_dec == '0) begin
							cuts_left_d = cuts_left_q - svcut_pkg::COUNT_W'(1);
							phase_d     = (cuts_left_d == '0) ?
								svcut_pkg::PH_IDLE : svcut_pkg::PH_START;
						end
					end
					default: ;
				endcase
			end
			svcut_pkg::OP_START: begin
				cuts_left_d = (cut_count_s1 == '0) ? svcut_pkg::COUNT_W'(1) : cut_count_s1;
				if (phase_q == svcut_pkg::PH_IDLE) begin
					phase_d = svcut_pkg::PH_START;
				end
			end
			svcut_pkg::OP_SET_ANGLE: begin
				map_req   = 1'b1;
				map_angle = angle_s1;
			end
			default: ;
		endcase
		upd       = map_req && map_ok[map_angle];
		compare_d = upd ? map_val[map_angle] : compare_q;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			pwm_compare_s2 <= compare_d;
			pwm_updated_s2 <= upd;
			status_s2      <= phase_d;
		end
	end

	// idle is only reached with the run used up, or straight out of reset
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == svcut_pkg::PH_IDLE |-> cuts_left_q <= svcut_pkg::COUNT_W'(1))
		else $error("idle phase with cuts still pending");

	// a processed beat always lands in the result register
	assert property (@(posedge clk) disable iff (!arst_n)
		step |=> m_tvalid_q)
		else $error("processed beat lost before result register");

	// the compare value only moves on a beat that reports an update
	assert property (@(posedge clk) disable iff (!arst_n)
		!(step && upd) |=> $stable(compare_q))
		else $error("compare value changed without update flag");

	// sequencer state holds while no beat is processed
	assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(phase_q) && $stable(delay_left_q))
		else $error("sequencer state moved without a beat");

endmodule
